[rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared constants, payload types and slot table control for the cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W          = 32;
    localparam int CFG_W          = 5;
    localparam int CAPACITY_DEF   = 16;
    localparam int HASH_SLOTS_DEF = 64;

    localparam logic [CFG_W-1:0]        CAP_RESET  = CFG_W'(16);
    localparam logic [KEY_W-1:0]        HASH_MULT  = 32'd2654435761;
    localparam logic signed [KEY_W-1:0] MISS_VALUE = -32'sd1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [KEY_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [KEY_W-1:0] read_value;
        logic                    evicted;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
        logic inv_en;
    } slot_ctl_t;

endpackage

[rtl/lkvc_slot_table.sv]
// ----------------------------------------------------------------------------
// Hash slot table
// Key/entry memory with a registered read port and a flop valid bit per slot.
// ----------------------------------------------------------------------------
module lkvc_slot_table #(
    parameter int HASH_SLOTS = lkvc_pkg::HASH_SLOTS_DEF,
    parameter int EW         = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkvc_pkg::slot_ctl_t           ctl,
    input  logic [$clog2(HASH_SLOTS)-1:0] addr,
    input  logic [lkvc_pkg::KEY_W-1:0]    wr_key,
    input  logic [EW-1:0]                 wr_entry,
    output logic                          q_valid,
    output logic [lkvc_pkg::KEY_W-1:0]    rd_key,
    output logic [EW-1:0]                 rd_entry
);
    import lkvc_pkg::*;

    logic [KEY_W+EW-1:0]   mem_reg [HASH_SLOTS];
    logic [KEY_W+EW-1:0]   rd_data_reg;
    logic [HASH_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[addr] <= {wr_key, wr_entry};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.inv_en)
            begin
                valid_reg[addr] <= 1'b0;
            end
        end
    end

    assign q_valid  = valid_reg[addr];
    assign rd_key   = rd_data_reg[KEY_W+EW-1:EW];
    assign rd_entry = rd_data_reg[EW-1:0];

endmodule

[rtl/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache
// Get/put cache with a recency list and a linear-probing hash slot table.
// ----------------------------------------------------------------------------
// One beat is taken at a time and the input stalls until its result is built.
// An item passes an accept step, a hash step through the shared multiplier,
// a probe of each empty slot reached and a probe and compare of each
// occupied slot, an unlink and a link step of list relinking on a hit or an
// eviction or a link step alone for a put into a free entry, and a result
// step. An eviction adds a hash and probe walk for the evicted key, then,
// for every slot of the following run, a check and a read step plus a fresh
// hash and probe walk, a check step at the end of the run, and a final hash
// and probe walk for the new key. HASH_SLOTS must be a power of two; the slot
// index is the low bits of the key multiplied by the golden-ratio constant.
// Writing the capacity register empties the cache at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
    parameter int CAPACITY   = lkvc_pkg::CAPACITY_DEF,
    parameter int HASH_SLOTS = lkvc_pkg::HASH_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  lkvc_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output lkvc_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata
);
    import lkvc_pkg::*;

    localparam int HB   = $clog2(HASH_SLOTS);
    localparam int EW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int MAXC = (CAPACITY < HASH_SLOTS - 1) ? CAPACITY : HASH_SLOTS - 1;
    localparam int CW   = (LW > CFG_W) ? LW : CFG_W;
    localparam logic [LW-1:0] NONE = LW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HASH   = 4'd1;
    localparam logic [3:0] S_PROBE  = 4'd2;
    localparam logic [3:0] S_PCMP   = 4'd3;
    localparam logic [3:0] S_SHIFT  = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_UNLINK = 4'd6;
    localparam logic [3:0] S_LINK   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic [1:0] M_LOOKUP  = 2'd0;
    localparam logic [1:0] M_REMOVE  = 2'd1;
    localparam logic [1:0] M_REPLACE = 2'd2;
    localparam logic [1:0] M_INSERT  = 2'd3;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] val_reg, val_next;
    logic [KEY_W-1:0] probe_key_reg, probe_key_next;
    logic [HB-1:0]    pos_reg, pos_next;
    logic [HB-1:0]    shift_pos_reg, shift_pos_next;
    logic             hit_reg, hit_next;
    logic             ev_reg, ev_next;
    logic [EW-1:0]    use_reg, use_next;
    logic [LW-1:0]    count_reg, count_next;
    logic [KEY_W-1:0] rdv_reg, rdv_next;
    logic [CFG_W-1:0] cap_reg, cap_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [LW-1:0]    older_reg [CAPACITY];
    logic [LW-1:0]    newer_reg [CAPACITY];
    logic [LW-1:0]    newest_reg, oldest_reg;
    logic [KEY_W-1:0] ekey_reg [CAPACITY];
    logic [KEY_W-1:0] eval_reg [CAPACITY];

    slot_ctl_t        ctl;
    logic             q_valid;
    logic [KEY_W-1:0] rd_key;
    logic [EW-1:0]    rd_entry;
    logic [KEY_W-1:0] hash_w;
    logic [CW-1:0]    cap_w, cap_eff;
    logic             full;
    logic [LW-1:0]    link_p, link_n;

    function automatic logic [HB-1:0] next_slot(input logic [HB-1:0] h);
        next_slot = (h == HB'(HASH_SLOTS - 1)) ? '0 : h + HB'(1);
    endfunction

    lkvc_slot_table #(
        .HASH_SLOTS (HASH_SLOTS),
        .EW         (EW)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .addr     (pos_reg),
        .wr_key   (probe_key_reg),
        .wr_entry (use_reg),
        .q_valid  (q_valid),
        .rd_key   (rd_key),
        .rd_entry (rd_entry)
    );

    assign hash_w = probe_key_reg * HASH_MULT;
    assign link_p = newer_reg[use_reg];
    assign link_n = older_reg[use_reg];

    always_comb
    begin
        cap_w = CW'(cap_reg);
        if (cap_w == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_w > CW'(MAXC))
        begin
            cap_eff = CW'(MAXC);
        end
        else
        begin
            cap_eff = cap_w;
        end
        full = (CW'(count_reg) >= cap_eff);
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        probe_key_next = probe_key_reg;
        pos_next       = pos_reg;
        shift_pos_next = shift_pos_reg;
        hit_next       = hit_reg;
        ev_next        = ev_reg;
        use_next       = use_reg;
        count_next     = count_reg;
        rdv_next       = rdv_reg;
        cap_next       = cap_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next       = req.cmd;
                    key_next       = req.lookup_key;
                    val_next       = req.store_value;
                    probe_key_next = req.lookup_key;
                    mode_next      = M_LOOKUP;
                    hit_next       = 1'b0;
                    ev_next        = 1'b0;
                    rdv_next       = MISS_VALUE;
                    state_next     = S_HASH;
                end
            end
            S_HASH:
            begin
                pos_next   = hash_w[HB-1:0];
                state_next = S_PROBE;
            end
            S_PROBE, S_PCMP:
            begin
                if (state_reg == S_PROBE && q_valid)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_PCMP;
                end
                else if (state_reg == S_PCMP && rd_key != probe_key_reg)
                begin
                    pos_next   = next_slot(pos_reg);
                    state_next = S_PROBE;
                end
                else
                begin
                    case (mode_reg)
                        M_LOOKUP:
                        begin
                            if (state_reg == S_PCMP)
                            begin
                                hit_next   = 1'b1;
                                use_next   = rd_entry;
                                if (cmd_reg == CMD_GET)
                                begin
                                    rdv_next = eval_reg[rd_entry];
                                end
                                state_next = S_UNLINK;
                            end
                            else if (cmd_reg == CMD_GET)
                            begin
                                state_next = S_OUT;
                            end
                            else if (!full)
                            begin
                                use_next   = count_reg[EW-1:0];
                                count_next = count_reg + LW'(1);
                                state_next = S_LINK;
                            end
                            else
                            begin
                                use_next       = oldest_reg[EW-1:0];
                                ev_next        = 1'b1;
                                probe_key_next = ekey_reg[oldest_reg[EW-1:0]];
                                mode_next      = M_REMOVE;
                                state_next     = S_HASH;
                            end
                        end
                        M_REMOVE:
                        begin
                            ctl.inv_en = 1'b1;
                            pos_next   = next_slot(pos_reg);
                            state_next = S_SHIFT;
                        end
                        M_REPLACE:
                        begin
                            ctl.wr_en  = 1'b1;
                            pos_next   = next_slot(shift_pos_reg);
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            ctl.wr_en  = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (q_valid)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_SHRD;
                end
                else
                begin
                    use_next   = oldest_reg[EW-1:0];
                    state_next = S_UNLINK;
                end
            end
            S_SHRD:
            begin
                ctl.inv_en     = 1'b1;
                shift_pos_next = pos_reg;
                probe_key_next = rd_key;
                use_next       = rd_entry;
                mode_next      = M_REPLACE;
                state_next     = S_HASH;
            end
            S_UNLINK:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (ev_reg)
                begin
                    probe_key_next = key_reg;
                    mode_next      = M_INSERT;
                    state_next     = S_HASH;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = hit_reg;
                    rsp_next.read_value = rdv_reg;
                    rsp_next.evicted    = ev_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mode_reg == M_LOOKUP && state_reg == S_LINK && !hit_reg)
        begin
            ctl.wr_en = 1'b1;
        end

        if (cfg_we)
        begin
            cap_next   = cfg_wdata;
            count_next = '0;
            ctl.clear  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_LOOKUP;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        probe_key_reg <= probe_key_next;
        pos_reg       <= pos_next;
        shift_pos_reg <= shift_pos_next;
        hit_reg       <= hit_next;
        ev_reg        <= ev_next;
        use_reg       <= use_next;
        rdv_reg       <= rdv_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                older_reg[i] <= NONE;
                newer_reg[i] <= NONE;
            end
            newest_reg <= NONE;
            oldest_reg <= NONE;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                older_reg[i] <= NONE;
                newer_reg[i] <= NONE;
            end
            newest_reg <= NONE;
            oldest_reg <= NONE;
        end
        else if (state_reg == S_UNLINK)
        begin
            if (link_p != NONE)
            begin
                older_reg[link_p[EW-1:0]] <= link_n;
            end
            else
            begin
                newest_reg <= link_n;
            end
            if (link_n != NONE)
            begin
                newer_reg[link_n[EW-1:0]] <= link_p;
            end
            else
            begin
                oldest_reg <= link_p;
            end
            newer_reg[use_reg] <= NONE;
            older_reg[use_reg] <= NONE;
        end
        else if (state_reg == S_LINK)
        begin
            newer_reg[use_reg] <= NONE;
            older_reg[use_reg] <= newest_reg;
            if (newest_reg != NONE)
            begin
                newer_reg[newest_reg[EW-1:0]] <= LW'(use_reg);
            end
            newest_reg <= LW'(use_reg);
            if (oldest_reg == NONE)
            begin
                oldest_reg <= LW'(use_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LINK && cmd_reg == CMD_PUT)
        begin
            eval_reg[use_reg] <= val_reg;
            if (!hit_reg)
            begin
                ekey_reg[use_reg] <= key_reg;
            end
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Port-level assertions on beats and result fields, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lkvc_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lkvc_pkg::rsp_t rsp
);
    import lkvc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled result beat changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("Input taken again while an item is in progress.");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.evicted))
        else $error("Result beat flags both a hit and an eviction.");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (!rsp.hit || rsp.evicted) |-> rsp.read_value == MISS_VALUE)
        else $error("Miss result carries a value other than minus one.");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
